/* rtl/core/geodetic_to_local_enu_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the geodetic to local ENU block
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GEODETIC_TO_LOCAL_ENU_MACROS_SVH
`define GEODETIC_TO_LOCAL_ENU_MACROS_SVH

// Check a property on every rising edge outside reset
`define G2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle
`define G2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  `G2E_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/core/g2e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_pkg
// Types, fixed point constants and helper functions of the ENU converter.
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int HGT_W = 28;
  localparam int OUT_W = 35;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;

  localparam int MUL_LAT = 4;
  localparam int MAX_STEPS = 48;
  localparam int CORDIC_STEPS_DEF = 32;
  localparam int NEWTON_STEPS = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [63:0] fx_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_REF_LAT = 2'd0,
    REG_REF_LON = 2'd1,
    REG_REF_HGT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [HGT_W-1:0] hgt;
  } item_t;

  // Q60 pi and derived Q40 angles
  localparam fx_t PI_Q60 = 64'sh3243F6A8885A308D;
  localparam fx_t PI_Q40 = (PI_Q60 + (64'sd1 <<< 19)) >>> 20;
  localparam fx_t HALF_PI_Q40 = (PI_Q60 + (64'sd1 <<< 20)) >>> 21;
  localparam fx_t TWO_PI_Q40 = (PI_Q60 + (64'sd1 <<< 18)) >>> 19;
  localparam fx_t ONE_Q40 = 64'sd1 <<< 40;
  localparam fx_t THREE_Q40 = 64'sd3 <<< 40;
  localparam fx_t SEMI_MAJOR_MM = 64'sd6378137000;
  localparam fx_t ECC_SQ_Q40 = 64'sd7360548651;
  localparam fx_t CORDIC_X0 = 64'sd667681663043;
  localparam fx_t OUT_LIMIT = 64'sd16000000000;
  localparam fx_t MM_ROUND = 64'sd1 <<< 19;

  // pi / 1.8e9 in Q90, truncated
  localparam logic [127:0] ANGLE_SCALE_W =
    ({64'd0, PI_Q60} << 30) / 128'd1800000000;
  localparam fx_t ANGLE_SCALE = fx_t'(ANGLE_SCALE_W[63:0]);

  // atan(2^-i) in Q40 from its power series, evaluated at elaboration
  function automatic fx_t atan_q40(int unsigned i);
    fx_t acc;
    logic [63:0] term;
    int unsigned k;
    acc = '0;
    if (i == 0) begin
      acc = (PI_Q60 + (64'sd1 <<< 21)) >>> 22;
    end else begin
      for (k = 1; i * k <= 62; k += 2) begin
        term = (64'd1 << (62 - i * k)) / 64'(k);
        if ((((k - 1) / 2) & 1) != 0) acc = acc - fx_t'(term);
        else acc = acc + fx_t'(term);
      end
      acc = (acc + (64'sd1 <<< 21)) >>> 22;
    end
    return acc;
  endfunction

  // Round a Q20 length to whole mm and clamp to the output range
  function automatic logic signed [OUT_W-1:0] to_field(fx_t v);
    fx_t mm;
    mm = (v + MM_ROUND) >>> 20;
    if (mm > OUT_LIMIT) mm = OUT_LIMIT;
    else if (mm < -OUT_LIMIT) mm = -OUT_LIMIT;
    return mm[OUT_W-1:0];
  endfunction

  function automatic int sc_lat(int steps);
    return MUL_LAT + 2 + steps;
  endfunction

  function automatic int cart_lat(int steps);
    return sc_lat(steps) + 2 * MUL_LAT + 1 + NEWTON_STEPS * (3 * MUL_LAT + 1)
           + MUL_LAT + 2 * MUL_LAT + 1;
  endfunction

  function automatic int back_lat(int steps);
    return cart_lat(steps) + 2 * MUL_LAT + 4;
  endfunction

endpackage

/* rtl/core/g2e_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_pipe
// Fixed length register chain that keeps side values aligned with the math.
// ----------------------------------------------------------------------------
module g2e_pipe #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sh_q [N];

  // Shift by one stage each cycle
  always_ff @(posedge clk_i) begin
    sh_q[0] <= d_i;
    for (int i = 1; i < N; i++) sh_q[i] <= sh_q[i-1];
  end

  assign q_o = sh_q[N-1];
endmodule

/* rtl/core/g2e_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_mul
// Four stage signed 64x64 multiplier with rounded right shift and clamp.
// ----------------------------------------------------------------------------
module g2e_mul
  import g2e_pkg::*;
#(
  parameter int SHIFT = 40
) (
  input  logic           clk_i,
  input  g2e_pkg::fx_t   a_i,
  input  g2e_pkg::fx_t   b_i,
  output g2e_pkg::fx_t   p_o
);
  localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

  logic [63:0]  ua_q, ub_q;
  logic [2:0]   neg_q;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod_q;
  logic [127:0] rnd_sum, quo;
  logic [63:0]  mag;
  fx_t          p_q;

  // Stage 1: magnitudes and sign
  always_ff @(posedge clk_i) begin
    ua_q     <= a_i[63] ? 64'(-a_i) : 64'(a_i);
    ub_q     <= b_i[63] ? 64'(-b_i) : 64'(b_i);
    neg_q[0] <= a_i[63] ^ b_i[63];
  end

  // Stage 2: 32x32 partial products
  always_ff @(posedge clk_i) begin
    p00_q    <= ua_q[31:0]  * ub_q[31:0];
    p01_q    <= ua_q[31:0]  * ub_q[63:32];
    p10_q    <= ua_q[63:32] * ub_q[31:0];
    p11_q    <= ua_q[63:32] * ub_q[63:32];
    neg_q[1] <= neg_q[0];
  end

  // Stage 3: full product
  always_ff @(posedge clk_i) begin
    prod_q   <= {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
                + {p11_q, 64'd0};
    neg_q[2] <= neg_q[1];
  end

  // Stage 4: round, shift, clamp, apply sign
  always_comb begin
    rnd_sum = prod_q + RND;
    quo     = rnd_sum >> SHIFT;
    mag     = (quo[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
  end

  always_ff @(posedge clk_i) begin
    p_q <= neg_q[2] ? -fx_t'(mag) : fx_t'(mag);
  end

  assign p_o = p_q;
endmodule

/* rtl/core/g2e_sincos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_sincos
// Angle scaling, quadrant fold and pipelined rotation-mode CORDIC.
// ----------------------------------------------------------------------------
module g2e_sincos
  import g2e_pkg::*;
#(
  parameter int STEPS = g2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  g2e_pkg::fx_t deg_i,
  output g2e_pkg::fx_t cos_o,
  output g2e_pkg::fx_t sin_o
);
  fx_t  z_rad;
  fx_t  z_w, z_f;
  logic neg_f;
  fx_t  x_q [STEPS+1];
  fx_t  y_q [STEPS+1];
  fx_t  z_q [STEPS+1];
  logic neg_q [STEPS+1];
  fx_t  cos_q, sin_q;

  // Scale 1e-7 degree to Q40 radians
  g2e_mul #(.SHIFT(50)) u_scale (
    .clk_i(clk_i), .a_i(deg_i), .b_i(ANGLE_SCALE), .p_o(z_rad)
  );

  // Fold into [-pi/2, pi/2]
  always_comb begin
    z_w   = z_rad;
    neg_f = 1'b0;
    if (z_rad > PI_Q40) z_w = z_rad - TWO_PI_Q40;
    else if (z_rad < -PI_Q40) z_w = z_rad + TWO_PI_Q40;
    z_f = z_w;
    if (z_w > HALF_PI_Q40) begin
      z_f   = z_w - PI_Q40;
      neg_f = 1'b1;
    end else if (z_w < -HALF_PI_Q40) begin
      z_f   = z_w + PI_Q40;
      neg_f = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CORDIC_X0;
    y_q[0]   <= '0;
    z_q[0]   <= z_f;
    neg_q[0] <= neg_f;
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam fx_t ATAN_I = atan_q40(i);
    always_ff @(posedge clk_i) begin
      if (!z_q[i][63]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN_I;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN_I;
      end
      neg_q[i+1] <= neg_q[i];
    end
  end

  // Undo the half-turn fold
  always_ff @(posedge clk_i) begin
    cos_q <= neg_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    sin_q <= neg_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;
endmodule

/* rtl/core/g2e_cart.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_cart
// Geodetic to earth-centred cartesian position, mm in Q20, fully pipelined.
// ----------------------------------------------------------------------------
module g2e_cart
  import g2e_pkg::*;
#(
  parameter int STEPS = g2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic signed [g2e_pkg::LAT_W-1:0] lat_i,
  input  logic signed [g2e_pkg::LON_W-1:0] lon_i,
  input  logic signed [g2e_pkg::HGT_W-1:0] hgt_i,
  output g2e_pkg::fx_t                     px_o,
  output g2e_pkg::fx_t                     py_o,
  output g2e_pkg::fx_t                     pz_o,
  output g2e_pkg::fx_t                     cl_o,
  output g2e_pkg::fx_t                     sl_o,
  output g2e_pkg::fx_t                     cp_o,
  output g2e_pkg::fx_t                     sp_o
);
  localparam int M   = MUL_LAT;
  localparam int SC  = sc_lat(STEPS);
  localparam int T2  = SC + 2 * M + 1;
  localparam int T3  = T2 + NEWTON_STEPS * (3 * M + 1);
  localparam int T4  = T3 + M;
  localparam int LAT = cart_lat(STEPS);

  fx_t cl, sl, cp, sp;
  fx_t s2, e_s2, w_q;
  fx_t y_s [NEWTON_STEPS+1];
  fx_t w_s [NEWTON_STEPS+1];
  fx_t n_v, ne, n_b, hq, hq_a, hq_b;
  fx_t nh_q, zz_q, rc;
  fx_t cl_d, cp_d, sp_d, sl_d;

  // Sine and cosine of latitude and longitude
  g2e_sincos #(.STEPS(STEPS)) u_lat (
    .clk_i(clk_i), .deg_i(fx_t'(lat_i)), .cos_o(cl), .sin_o(sl)
  );
  g2e_sincos #(.STEPS(STEPS)) u_lon (
    .clk_i(clk_i), .deg_i(fx_t'(lon_i)), .cos_o(cp), .sin_o(sp)
  );

  // w = 1 - e2 sin^2(lat)
  g2e_mul #(.SHIFT(40)) u_s2 (.clk_i(clk_i), .a_i(sl), .b_i(sl), .p_o(s2));
  g2e_mul #(.SHIFT(40)) u_es2 (.clk_i(clk_i), .a_i(ECC_SQ_Q40), .b_i(s2), .p_o(e_s2));

  always_ff @(posedge clk_i) begin
    w_q <= ONE_Q40 - e_s2;
  end

  assign y_s[0] = ONE_Q40;
  assign w_s[0] = w_q;

  // Newton steps toward 1/sqrt(w)
  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
    fx_t yy, w_m, wyy, y_d;
    fx_t corr_q;
    g2e_mul #(.SHIFT(40)) u_yy (.clk_i(clk_i), .a_i(y_s[k]), .b_i(y_s[k]), .p_o(yy));
    g2e_pipe #(.W(64), .N(M)) u_wm (.clk_i(clk_i), .d_i(w_s[k]), .q_o(w_m));
    g2e_mul #(.SHIFT(40)) u_wyy (.clk_i(clk_i), .a_i(w_m), .b_i(yy), .p_o(wyy));
    always_ff @(posedge clk_i) begin
      corr_q <= THREE_Q40 - wyy;
    end
    g2e_pipe #(.W(64), .N(2 * M + 1)) u_yd (.clk_i(clk_i), .d_i(y_s[k]), .q_o(y_d));
    g2e_mul #(.SHIFT(41)) u_yn (.clk_i(clk_i), .a_i(y_d), .b_i(corr_q), .p_o(y_s[k+1]));
    g2e_pipe #(.W(64), .N(3 * M + 1)) u_wn (.clk_i(clk_i), .d_i(w_s[k]), .q_o(w_s[k+1]));
  end

  // Prime vertical radius and height terms
  g2e_mul #(.SHIFT(20)) u_n (
    .clk_i(clk_i), .a_i(SEMI_MAJOR_MM), .b_i(y_s[NEWTON_STEPS]), .p_o(n_v)
  );
  g2e_mul #(.SHIFT(40)) u_ne (.clk_i(clk_i), .a_i(n_v), .b_i(ECC_SQ_Q40), .p_o(ne));
  g2e_pipe #(.W(64), .N(M)) u_nb (.clk_i(clk_i), .d_i(n_v), .q_o(n_b));

  assign hq = fx_t'(hgt_i) <<< 20;
  g2e_pipe #(.W(64), .N(T4)) u_hqa (.clk_i(clk_i), .d_i(hq), .q_o(hq_a));
  g2e_pipe #(.W(64), .N(M)) u_hqb (.clk_i(clk_i), .d_i(hq_a), .q_o(hq_b));

  always_ff @(posedge clk_i) begin
    nh_q <= n_v + hq_a;
    zz_q <= n_b - ne + hq_b;
  end

  // Align trig values with the radius terms
  g2e_pipe #(.W(64), .N(T4 + 1 - SC)) u_cld (.clk_i(clk_i), .d_i(cl), .q_o(cl_d));
  g2e_pipe #(.W(64), .N(T4 + 1 + M - SC)) u_cpd (.clk_i(clk_i), .d_i(cp), .q_o(cp_d));
  g2e_pipe #(.W(64), .N(T4 + 1 + M - SC)) u_spd (.clk_i(clk_i), .d_i(sp), .q_o(sp_d));
  g2e_pipe #(.W(64), .N(T4 + 1 + M - SC)) u_sld (.clk_i(clk_i), .d_i(sl), .q_o(sl_d));

  // Cartesian coordinates
  g2e_mul #(.SHIFT(40)) u_rc (.clk_i(clk_i), .a_i(nh_q), .b_i(cl_d), .p_o(rc));
  g2e_mul #(.SHIFT(40)) u_px (.clk_i(clk_i), .a_i(rc), .b_i(cp_d), .p_o(px_o));
  g2e_mul #(.SHIFT(40)) u_py (.clk_i(clk_i), .a_i(rc), .b_i(sp_d), .p_o(py_o));
  g2e_mul #(.SHIFT(40)) u_pz (.clk_i(clk_i), .a_i(zz_q), .b_i(sl_d), .p_o(pz_o));

  // Trig values at the output time
  g2e_pipe #(.W(64), .N(LAT - SC)) u_clo (.clk_i(clk_i), .d_i(cl), .q_o(cl_o));
  g2e_pipe #(.W(64), .N(LAT - SC)) u_slo (.clk_i(clk_i), .d_i(sl), .q_o(sl_o));
  g2e_pipe #(.W(64), .N(LAT - SC)) u_cpo (.clk_i(clk_i), .d_i(cp), .q_o(cp_o));
  g2e_pipe #(.W(64), .N(LAT - SC)) u_spo (.clk_i(clk_i), .d_i(sp), .q_o(sp_o));
endmodule

/* rtl/core/g2e_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_front
// Command intake and short word queue feeding the conversion pipeline.
// ----------------------------------------------------------------------------
`include "geodetic_to_local_enu_macros.svh"
module g2e_front
  import g2e_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [g2e_pkg::LAT_W-1:0] lat_i,
  input  logic signed [g2e_pkg::LON_W-1:0] lon_i,
  input  logic signed [g2e_pkg::HGT_W-1:0] hgt_i,
  output logic                             valid_o,
  output g2e_pkg::item_t                   item_o
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t       mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q, cnt_d;
  logic          push, pop;

  assign busy_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign push    = start_i && !busy_o;
  assign pop     = (cnt_q != '0);
  assign valid_o = pop;
  assign item_o  = mem_q[rd_ptr_q];

  // Store accepted words
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= '{lat: lat_i, lon: lon_i, hgt: hgt_i};
  end

  always_comb begin
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(pop);
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  `G2E_ASSERT_NEXT(a_push_seen, push, valid_o, "accepted word not presented")
  `G2E_ASSERT(a_cnt_bound, cnt_q <= (AW+1)'(QUEUE_DEPTH), "queue overfilled")
  `G2E_ASSERT_NEXT(a_drain, pop && !push && cnt_q == (AW+1)'(1), !valid_o,
                   "queue word repeated")
endmodule

/* rtl/core/g2e_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_back
// Point and reference cartesian conversion, difference and ENU rotation.
// ----------------------------------------------------------------------------
`include "geodetic_to_local_enu_macros.svh"
module g2e_back
  import g2e_pkg::*;
#(
  parameter int STEPS = g2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  g2e_pkg::item_t                   item_i,
  input  g2e_pkg::item_t                   ref_i,
  output logic                             valid_o,
  output logic signed [g2e_pkg::OUT_W-1:0] east_o,
  output logic signed [g2e_pkg::OUT_W-1:0] north_o,
  output logic signed [g2e_pkg::OUT_W-1:0] up_o
);
  localparam int M   = MUL_LAT;
  localparam int LAT = back_lat(STEPS);

  fx_t px, py, pz, rx, ry, rz;
  fx_t cl, sl, cp, sp, pcl, psl, pcp, psp;
  fx_t dx_q, dy_q, dz_q;
  fx_t cp_d, sp_d, cl_d, sl_d, dz_d;
  fx_t m_a, m_b, m_c, m_d;
  fx_t t_q, e_q, e_d;
  fx_t m_ts, m_cz, m_ct, m_sz;
  fx_t e_s_q, n_s_q, u_s_q;
  logic signed [OUT_W-1:0] east_q, north_q, up_q;
  logic [LAT-1:0] vld_q;

  g2e_cart #(.STEPS(STEPS)) u_pt (
    .clk_i(clk_i), .lat_i(item_i.lat), .lon_i(item_i.lon), .hgt_i(item_i.hgt),
    .px_o(px), .py_o(py), .pz_o(pz),
    .cl_o(pcl), .sl_o(psl), .cp_o(pcp), .sp_o(psp)
  );
  g2e_cart #(.STEPS(STEPS)) u_ref (
    .clk_i(clk_i), .lat_i(ref_i.lat), .lon_i(ref_i.lon), .hgt_i(ref_i.hgt),
    .px_o(rx), .py_o(ry), .pz_o(rz),
    .cl_o(cl), .sl_o(sl), .cp_o(cp), .sp_o(sp)
  );

  // Offset from the reference
  always_ff @(posedge clk_i) begin
    dx_q <= px - rx;
    dy_q <= py - ry;
    dz_q <= pz - rz;
  end

  g2e_pipe #(.W(64), .N(1)) u_cpd (.clk_i(clk_i), .d_i(cp), .q_o(cp_d));
  g2e_pipe #(.W(64), .N(1)) u_spd (.clk_i(clk_i), .d_i(sp), .q_o(sp_d));

  // Longitude rotation
  g2e_mul #(.SHIFT(40)) u_ma (.clk_i(clk_i), .a_i(cp_d), .b_i(dx_q), .p_o(m_a));
  g2e_mul #(.SHIFT(40)) u_mb (.clk_i(clk_i), .a_i(sp_d), .b_i(dy_q), .p_o(m_b));
  g2e_mul #(.SHIFT(40)) u_mc (.clk_i(clk_i), .a_i(sp_d), .b_i(dx_q), .p_o(m_c));
  g2e_mul #(.SHIFT(40)) u_md (.clk_i(clk_i), .a_i(cp_d), .b_i(dy_q), .p_o(m_d));

  always_ff @(posedge clk_i) begin
    t_q <= -m_a - m_b;
    e_q <= m_d - m_c;
  end

  g2e_pipe #(.W(64), .N(M + 1)) u_dzd (.clk_i(clk_i), .d_i(dz_q), .q_o(dz_d));
  g2e_pipe #(.W(64), .N(M + 2)) u_cld (.clk_i(clk_i), .d_i(cl), .q_o(cl_d));
  g2e_pipe #(.W(64), .N(M + 2)) u_sld (.clk_i(clk_i), .d_i(sl), .q_o(sl_d));
  g2e_pipe #(.W(64), .N(M)) u_ed (.clk_i(clk_i), .d_i(e_q), .q_o(e_d));

  // Latitude rotation
  g2e_mul #(.SHIFT(40)) u_ts (.clk_i(clk_i), .a_i(t_q), .b_i(sl_d), .p_o(m_ts));
  g2e_mul #(.SHIFT(40)) u_cz (.clk_i(clk_i), .a_i(cl_d), .b_i(dz_d), .p_o(m_cz));
  g2e_mul #(.SHIFT(40)) u_ct (.clk_i(clk_i), .a_i(cl_d), .b_i(t_q), .p_o(m_ct));
  g2e_mul #(.SHIFT(40)) u_sz (.clk_i(clk_i), .a_i(sl_d), .b_i(dz_d), .p_o(m_sz));

  always_ff @(posedge clk_i) begin
    e_s_q <= e_d;
    n_s_q <= m_ts + m_cz;
    u_s_q <= m_sz - m_ct;
  end

  // Round to mm and clamp
  always_ff @(posedge clk_i) begin
    east_q  <= to_field(e_s_q);
    north_q <= to_field(n_s_q);
    up_q    <= to_field(u_s_q);
  end

  // Track valid words through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign east_o  = east_q;
  assign north_o = north_q;
  assign up_o    = up_q;

  `G2E_ASSERT(a_lat_fwd, valid_i |-> ##LAT valid_o, "result missing after latency")
  `G2E_ASSERT(a_lat_bwd, valid_o |-> $past(valid_i, LAT), "result without a word")
endmodule

/* rtl/core/geodetic_to_local_enu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_to_local_enu
// WGS-84 latitude, longitude and height to east, north, up offsets in mm.
// ----------------------------------------------------------------------------
// Takes one position per clock: a word is accepted when start is high and busy
// is low, and its east, north and up offsets appear for one cycle with done_o
// high once it has passed the fixed pipeline: a CORDIC stage per step, six
// Newton steps for 1/sqrt built from four stage multipliers, and the ENU
// rotation. Results cannot be held off, so the output must be taken when
// done_o is high. Reference registers are written through the cfg port; the
// user must write them while no word is in flight, as the block does not
// enforce it; writes to an unused index are dropped.
module geodetic_to_local_enu
  import g2e_pkg::*;
#(
  parameter int CORDIC_STEPS = g2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [g2e_pkg::LAT_W-1:0]  latitude_i,
  input  logic signed [g2e_pkg::LON_W-1:0]  longitude_i,
  input  logic signed [g2e_pkg::HGT_W-1:0]  height_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [g2e_pkg::CFG_AW-1:0]        cfg_index_i,
  input  logic [g2e_pkg::CFG_DW-1:0]        cfg_data_i,
  output logic                              done_o,
  output logic signed [g2e_pkg::OUT_W-1:0]  east_o,
  output logic signed [g2e_pkg::OUT_W-1:0]  north_o,
  output logic signed [g2e_pkg::OUT_W-1:0]  up_o
);
  item_t ref_q;
  item_t q_item;
  logic  q_valid;

  assign cfg_ready_o = 1'b1;

  // Reference point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_REF_LAT: ref_q.lat <= cfg_data_i[LAT_W-1:0];
        REG_REF_LON: ref_q.lon <= cfg_data_i[LON_W-1:0];
        REG_REF_HGT: ref_q.hgt <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  g2e_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .start_i(start), .busy_o(busy),
    .lat_i(latitude_i), .lon_i(longitude_i), .hgt_i(height_i),
    .valid_o(q_valid), .item_o(q_item)
  );

  g2e_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(q_valid), .item_i(q_item), .ref_i(ref_q),
    .valid_o(done_o), .east_o(east_o), .north_o(north_o), .up_o(up_o)
  );
endmodule

/* dv/tb_geodetic_to_local_enu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geodetic_to_local_enu
// Self-checking bench for the WGS-84 position to local ENU offset converter.
// ----------------------------------------------------------------------------
// Positions are sent through the start/busy port with random gaps. A built-in
// fixed point predictor derives the expected east, north and up offsets for
// every accepted word. A monitor compares each done_o word with the oldest
// prediction. Reference registers are rewritten between phases while the
// pipeline is empty, including the extremes and an unused index.
// ----------------------------------------------------------------------------
module tb_geodetic_to_local_enu;
  import g2e_pkg::*;

  typedef logic signed [63:0] q_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] east;
    logic signed [OUT_W-1:0] north;
    logic signed [OUT_W-1:0] up;
  } enu_t;

  typedef struct packed {
    q_t c;
    q_t s;
  } trig_t;

  typedef struct packed {
    q_t px;
    q_t py;
    q_t pz;
    trig_t lat_t;
    trig_t lon_t;
  } ecef_t;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;
  localparam q_t A_MM = 64'sd6378137000;
  localparam q_t E2_Q40 = 64'sd7360548651;
  localparam q_t GAIN_INV = 64'sd667681663043;
  localparam q_t PI60 = 64'sh3243F6A8885A308D;
  localparam q_t PI40 = (PI60 + (64'sd1 <<< 19)) >>> 20;
  localparam q_t HPI40 = (PI60 + (64'sd1 <<< 20)) >>> 21;
  localparam q_t TPI40 = (PI60 + (64'sd1 <<< 18)) >>> 19;
  localparam q_t UNITY = 64'sd1 <<< 40;
  localparam q_t MM_SAT = 64'sd16000000000;
  localparam logic [127:0] DEG_SCALE_W = ({64'd0, PI60} << 30) / 128'd1800000000;
  localparam q_t DEG_SCALE = DEG_SCALE_W[63:0];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [LAT_W-1:0] latitude_i = '0;
  logic signed [LON_W-1:0] longitude_i = '0;
  logic signed [HGT_W-1:0] height_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_AW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [OUT_W-1:0] east_o, north_o, up_o;

  // reference origin as held by the block
  logic [LAT_W-1:0] org_lat = '0;
  logic [LON_W-1:0] org_lon = '0;
  logic [HGT_W-1:0] org_hgt = '0;

  q_t atan_tab[MAX_STEPS];
  enu_t enu_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int cfg_writes = 0;

  geodetic_to_local_enu u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .latitude_i(latitude_i), .longitude_i(longitude_i), .height_i(height_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .east_o(east_o), .north_o(north_o), .up_o(up_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Rounded product: ties away from zero, saturated magnitude
  function automatic q_t rmul(q_t a, q_t b, int sh);
    logic [63:0] ua, ub;
    logic [127:0] p;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'd0 - a : a;
    ub = (b < 0) ? 64'd0 - b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -q_t'(p[63:0]) : q_t'(p[63:0]);
  endfunction

  // Arctangent series in Q62, rounded to Q40
  function automatic q_t atan_step(int i);
    q_t acc;
    logic [63:0] term;
    int k;
    acc = 0;
    if (i == 0) return (PI60 + (64'sd1 <<< 21)) >>> 22;
    for (k = 1; i * k <= 62; k += 2) begin
      term = (64'd1 << (62 - i * k)) / 64'(k);
      if (((k - 1) / 2) % 2 == 1) acc = acc - q_t'(term);
      else acc = acc + q_t'(term);
    end
    return (acc + (64'sd1 <<< 21)) >>> 22;
  endfunction

  // Rotation CORDIC with folding into the right half plane
  function automatic trig_t rotate(q_t deg7);
    q_t z, x, y, dx, dy;
    logic flip;
    trig_t r;
    z = rmul(deg7, DEG_SCALE, 50);
    x = GAIN_INV;
    y = 0;
    flip = 1'b0;
    if (z > PI40) z = z - TPI40;
    else if (z < -PI40) z = z + TPI40;
    if (z > HPI40) begin
      z = z - PI40;
      flip = 1'b1;
    end else if (z < -HPI40) begin
      z = z + PI40;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    r.c = flip ? -x : x;
    r.s = flip ? -y : y;
    return r;
  endfunction

  // Earth-centred position in mm Q20
  function automatic ecef_t to_ecef(q_t lat, q_t lon, q_t hgt);
    ecef_t e;
    q_t w, y, n, hq, rc;
    e.lat_t = rotate(lat);
    e.lon_t = rotate(lon);
    w = UNITY - rmul(E2_Q40, rmul(e.lat_t.s, e.lat_t.s, 40), 40);
    y = UNITY;
    for (int k = 0; k < 6; k++)
      y = rmul(y, 3 * UNITY - rmul(w, rmul(y, y, 40), 40), 41);
    n = rmul(A_MM, y, 20);
    hq = hgt <<< 20;
    rc = rmul(n + hq, e.lat_t.c, 40);
    e.px = rmul(rc, e.lon_t.c, 40);
    e.py = rmul(rc, e.lon_t.s, 40);
    e.pz = rmul(n - rmul(n, E2_Q40, 40) + hq, e.lat_t.s, 40);
    return e;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_mm(q_t v);
    q_t mm;
    mm = (v + (64'sd1 <<< 19)) >>> 20;
    if (mm > MM_SAT) mm = MM_SAT;
    if (mm < -MM_SAT) mm = -MM_SAT;
    return mm[OUT_W-1:0];
  endfunction

  function automatic enu_t predict_enu(logic signed [LAT_W-1:0] lat,
                                       logic signed [LON_W-1:0] lon,
                                       logic signed [HGT_W-1:0] hgt);
    ecef_t p, r;
    q_t dx, dy, dz, t;
    enu_t o;
    p = to_ecef(lat, lon, hgt);
    r = to_ecef($signed(org_lat), $signed(org_lon), $signed(org_hgt));
    dx = p.px - r.px;
    dy = p.py - r.py;
    dz = p.pz - r.pz;
    t = -rmul(r.lon_t.c, dx, 40) - rmul(r.lon_t.s, dy, 40);
    o.east = to_mm(-rmul(r.lon_t.s, dx, 40) + rmul(r.lon_t.c, dy, 40));
    o.north = to_mm(rmul(t, r.lat_t.s, 40) + rmul(r.lat_t.c, dz, 40));
    o.up = to_mm(-rmul(r.lat_t.c, t, 40) + rmul(r.lat_t.s, dz, 40));
    return o;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one position; start stays high after acceptance
  task automatic send_pos(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                          logic signed [HGT_W-1:0] hgt, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    latitude_i <= lat;
    longitude_i <= lon;
    height_i <= hgt;
    do @(posedge clk_i); while (busy);
    enu_q.push_back(predict_enu(lat, lon, hgt));
    sent++;
  endtask

  // Hold until the pipeline is empty
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (enu_q.size() != 0) @(posedge clk_i);
    repeat (STEPS + 130) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_REF_LAT: org_lat = data[LAT_W-1:0];
      REG_REF_LON: org_lon = data[LON_W-1:0];
      REG_REF_HGT: org_hgt = data[HGT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_origin(int lat, int lon, int hgt);
    drain();
    write_reg(REG_REF_LAT, lat);
    write_reg(REG_REF_LON, lon);
    write_reg(REG_REF_HGT, hgt);
  endtask

  function automatic logic signed [LAT_W-1:0] rnd_lat(bit wild);
    if (wild) return LAT_W'($urandom());
    return LAT_W'(int'($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic signed [LON_W-1:0] rnd_lon(bit wild);
    if (wild) return LON_W'($urandom());
    return LON_W'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
  endfunction

  function automatic logic signed [HGT_W-1:0] rnd_hgt(bit wild);
    if (wild) return HGT_W'($urandom());
    if ($urandom_range(0, 3) == 0)
      return HGT_W'(int'($urandom_range(0, 101000000)) - 1000000);
    return HGT_W'(int'($urandom_range(0, 20000000)) - 1000000);
  endfunction

  // Field extremes against the reset origin
  task automatic test_field_extremes();
    send_pos(0, 0, 0, 0);
    send_pos(900000000, 0, 0, 0);
    send_pos(-900000000, 0, 0, pick_gap());
    send_pos(0, 1800000000, 0, 0);
    send_pos(0, -1800000000, 100000000, 0);
    send_pos(450000000, 900000000, -1000000, pick_gap());
    send_pos(-450000000, -900000000, 100000000, 0);
    // beyond the stated ranges: folded angles, height as given
    send_pos(-31'sd1073741824, -32'sd2147483648, -28'sd134217728, 0);
    send_pos(31'sd1073741823, 32'sd2147483647, 28'sd134217727, 0);
    send_pos(31'sd1000000000, -32'sd2000000000, 28'sd120000000, pick_gap());
    send_pos(1, -1, 1, 0);
    send_pos(-1, 1, -1, 0);
  endtask

  // Origins at the corners, plus a write to the unused index
  task automatic test_origin_extremes();
    set_origin(900000000, 1800000000, 100000000);
    send_pos(900000000, 1800000000, 100000000, 0);
    send_pos(-900000000, 0, -1000000, 0);
    set_origin(-900000000, -1800000000, -1000000);
    send_pos(-900000000, -1800000000, -1000000, 0);
    send_pos(900000000, 0, 100000000, 0);
    set_origin(31'sd1073741823, 32'sd2147483647, 28'sd134217727);
    send_pos(0, 0, 0, 0);
    set_origin(-31'sd1073741824, -32'sd2147483648, -28'sd134217728);
    send_pos(0, 0, 0, 0);
    set_origin(473977000, 85450000, 408000);
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pos(473978000, 85460000, 410000, 0);
    send_pos(474000000, 85400000, 500000, 0);
  endtask

  // Random positions, half of them near the origin, under several origins
  task automatic test_random_stream();
    int near;
    bit burst;
    for (int ph = 0; ph < 6; ph++) begin
      set_origin(rnd_lat(ph == 5), rnd_lon(ph == 5), rnd_hgt(ph == 5));
      burst = (ph % 2) == 1;
      for (int i = 0; i < 95; i++) begin
        near = $urandom_range(0, 9);
        if (i == 50) drain();
        if (near < 5)
          send_pos($signed(org_lat) + $signed(12'($urandom())),
                   $signed(org_lon) + $signed(20'($urandom())),
                   rnd_hgt(1'b0), burst ? 0 : pick_gap());
        else
          send_pos(rnd_lat(near == 9), rnd_lon(near == 9), rnd_hgt(near == 9),
                   burst ? 0 : pick_gap());
      end
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    enu_t e;
    if (rst_ni && done_o) begin
      if (enu_q.size() == 0) begin
        $display("%0t: result with nothing pending: east %0d north %0d up %0d",
                 $time, east_o, north_o, up_o);
        errors++;
      end else begin
        e = enu_q.pop_front();
        checked++;
        if (east_o !== e.east) begin
          $display("%0t: east expected %0d actual %0d", $time, e.east, east_o);
          errors++;
        end
        if (north_o !== e.north) begin
          $display("%0t: north expected %0d actual %0d", $time, e.north, north_o);
          errors++;
        end
        if (up_o !== e.up) begin
          $display("%0t: up expected %0d actual %0d", $time, e.up, up_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("tb_geodetic_to_local_enu: errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_STEPS; i++) atan_tab[i] = atan_step(i);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_origin_extremes();
    test_random_stream();
    drain();
    if (enu_q.size() != 0) errors++;
    $display("Sent %0d positions, checked %0d offsets, %0d register writes.",
             sent, checked, cfg_writes);
    $display("Covered field and origin extremes, folded angles and random streams.");
    if (errors == 0) begin
      $display("tb_geodetic_to_local_enu: clean");
    end else begin
      $display("tb_geodetic_to_local_enu: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/g2e_pkg.sv
rtl/core/g2e_pipe.sv
rtl/core/g2e_mul.sv
rtl/core/g2e_sincos.sv
rtl/core/g2e_cart.sv
rtl/core/g2e_front.sv
rtl/core/g2e_back.sv
rtl/core/geodetic_to_local_enu.sv
dv/tb_geodetic_to_local_enu.sv
